FILE: sv/sha1bh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bh_pkg
// Shared types and constants of the SHA-1 byte stream hasher: item formats,
// initial hash words, round constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

    // initial chaining value
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // round constants
    localparam logic [31:0] K_CH     = 32'h5A827999;
    localparam logic [31:0] K_PAR1   = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2   = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    localparam int unsigned ROUNDS_PER_BLOCK = 80;
    localparam logic [6:0]  LAST_ROUND       = 7'(ROUNDS_PER_BLOCK - 1);
    localparam logic [5:0]  LAST_BYTE_POS    = 6'd63;
    localparam logic [5:0]  LEN_START_POS    = 6'd56;
    localparam logic [2:0]  LAST_LEN_BYTE    = 3'd7;

    // item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } digest_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUNDS,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } round_phase_t;

    // controller to datapath
    typedef struct packed {
        logic         push;
        byte_sel_t    byte_sel;
        logic         count_byte;
        logic         cap_len;
        logic         shift_len;
        logic         start_block;
        logic         round;
        round_phase_t phase;
        logic         fold;
        logic         load_out;
        logic         restart;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       emit_ok;
    } status_t;

endpackage

FILE: sv/sha1bh_stream_if.sv
// ----------------------------------------------------------------------------
// sha1bh_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface sha1bh_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/sha1bh_ctrl.sv
// ----------------------------------------------------------------------------
// sha1bh_ctrl
// Sequencer of the hasher: takes items, drives padding, steps the 80 rounds
// of each block and hands the digest to the output register.
// ----------------------------------------------------------------------------
module sha1bh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    output logic                in_ready,
    input  sha1bh_pkg::status_t status,
    output sha1bh_pkg::cmd_t    cmd
);

    sha1bh_pkg::state_t state_reg, state_next;
    sha1bh_pkg::state_t resume_reg, resume_next;
    logic               finish_reg, finish_next;
    logic [6:0]         round_reg, round_next;
    logic [2:0]         len_cnt_reg, len_cnt_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sha1bh_pkg::ST_IDLE;
            resume_reg  <= sha1bh_pkg::ST_IDLE;
            finish_reg  <= 1'b0;
            round_reg   <= '0;
            len_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            resume_reg  <= resume_next;
            finish_reg  <= finish_next;
            round_reg   <= round_next;
            len_cnt_reg <= len_cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        resume_next  = resume_reg;
        finish_next  = finish_reg;
        round_next   = round_reg;
        len_cnt_next = len_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.byte_sel = sha1bh_pkg::SEL_DATA;

        // round function group from the round number
        if (round_reg < 7'd20)
            cmd.phase = sha1bh_pkg::PH_CH;
        else if (round_reg < 7'd40)
            cmd.phase = sha1bh_pkg::PH_PAR1;
        else if (round_reg < 7'd60)
            cmd.phase = sha1bh_pkg::PH_MAJ;
        else
            cmd.phase = sha1bh_pkg::PH_PAR2;

        unique case (state_reg)
            sha1bh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == sha1bh_pkg::KIND_DATA)
                    begin
                        cmd.push       = 1'b1;
                        cmd.count_byte = 1'b1;
                        if (status.fill == sha1bh_pkg::LAST_BYTE_POS)
                        begin
                            cmd.start_block = 1'b1;
                            round_next      = '0;
                            resume_next     = sha1bh_pkg::ST_IDLE;
                            state_next      = sha1bh_pkg::ST_ROUNDS;
                        end
                    end
                    else
                    begin
                        cmd.cap_len = 1'b1;
                        finish_next = 1'b1;
                        state_next  = sha1bh_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha1bh_pkg::ST_PAD_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha1bh_pkg::SEL_MARK;
                state_next   = sha1bh_pkg::ST_PAD_ZERO;
                if (status.fill == sha1bh_pkg::LAST_BYTE_POS)
                begin
                    cmd.start_block = 1'b1;
                    round_next      = '0;
                    resume_next     = sha1bh_pkg::ST_PAD_ZERO;
                    state_next      = sha1bh_pkg::ST_ROUNDS;
                end
            end
            sha1bh_pkg::ST_PAD_ZERO:
            begin
                if (status.fill == sha1bh_pkg::LEN_START_POS)
                begin
                    len_cnt_next = '0;
                    state_next   = sha1bh_pkg::ST_PAD_LEN;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = sha1bh_pkg::SEL_ZERO;
                    if (status.fill == sha1bh_pkg::LAST_BYTE_POS)
                    begin
                        cmd.start_block = 1'b1;
                        round_next      = '0;
                        resume_next     = sha1bh_pkg::ST_PAD_ZERO;
                        state_next      = sha1bh_pkg::ST_ROUNDS;
                    end
                end
            end
            sha1bh_pkg::ST_PAD_LEN:
            begin
                cmd.push      = 1'b1;
                cmd.byte_sel  = sha1bh_pkg::SEL_LEN;
                cmd.shift_len = 1'b1;
                len_cnt_next  = len_cnt_reg + 3'd1;
                if (len_cnt_reg == sha1bh_pkg::LAST_LEN_BYTE)
                begin
                    cmd.start_block = 1'b1;
                    round_next      = '0;
                    resume_next     = sha1bh_pkg::ST_EMIT;
                    state_next      = sha1bh_pkg::ST_ROUNDS;
                end
            end
            sha1bh_pkg::ST_ROUNDS:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == sha1bh_pkg::LAST_ROUND)
                    state_next = sha1bh_pkg::ST_FOLD;
            end
            sha1bh_pkg::ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = finish_reg ? resume_reg : sha1bh_pkg::ST_IDLE;
            end
            sha1bh_pkg::ST_EMIT:
            begin
                if (status.emit_ok)
                begin
                    cmd.load_out = 1'b1;
                    cmd.restart  = 1'b1;
                    finish_next  = 1'b0;
                    state_next   = sha1bh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1bh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sha1bh_datapath.sv
// ----------------------------------------------------------------------------
// sha1bh_datapath
// Block buffer and message schedule window, one SHA-1 round per cycle,
// chaining value, length counter and the digest output register.
// ----------------------------------------------------------------------------
module sha1bh_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  sha1bh_pkg::cmd_t     cmd,
    output sha1bh_pkg::status_t  status,
    sha1bh_stream_if.source      digest
);

    // sixteen-word window, word 0 in the top bits
    logic [511:0] window_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [63:0]  len_reg;
    logic [31:0]  h_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic         out_valid_reg;
    sha1bh_pkg::digest_item_t out_reg;

    logic [7:0]  byte_in;
    logic [31:0] w_cur, w_mix, w_new, f_val, k_val, t_val;

    // byte source for the block buffer
    always_comb
    begin
        case (cmd.byte_sel)
            sha1bh_pkg::SEL_DATA: byte_in = data_byte;
            sha1bh_pkg::SEL_MARK: byte_in = sha1bh_pkg::PAD_MARK_BYTE;
            sha1bh_pkg::SEL_ZERO: byte_in = 8'h00;
            sha1bh_pkg::SEL_LEN:  byte_in = len_reg[63:56];
            default:              byte_in = 8'h00;
        endcase
    end

    // schedule recurrence over the window taps 0, 2, 8 and 13
    assign w_cur = window_reg[511:480];
    assign w_mix = window_reg[511:480] ^ window_reg[447:416]
                 ^ window_reg[255:224] ^ window_reg[95:64];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // round function and constant
    always_comb
    begin
        case (cmd.phase)
            sha1bh_pkg::PH_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1bh_pkg::K_CH;
            end
            sha1bh_pkg::PH_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1bh_pkg::K_PAR1;
            end
            sha1bh_pkg::PH_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1bh_pkg::K_MAJ;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1bh_pkg::K_PAR2;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // block buffer and schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            window_reg <= {window_reg[503:0], byte_in};
        else if (cmd.round)
            window_reg <= {window_reg[479:0], w_new};
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.start_block)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // bit length, shifted out top byte first
    always_ff @(posedge clk)
    begin
        if (cmd.cap_len)
            len_reg <= {total_reg, 3'b000};
        else if (cmd.shift_len)
            len_reg <= {len_reg[55:0], 8'h00};
    end

    // fill position, byte count and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            h_reg[0]  <= sha1bh_pkg::IV0;
            h_reg[1]  <= sha1bh_pkg::IV1;
            h_reg[2]  <= sha1bh_pkg::IV2;
            h_reg[3]  <= sha1bh_pkg::IV3;
            h_reg[4]  <= sha1bh_pkg::IV4;
        end
        else
        begin
            if (cmd.restart)
                fill_reg <= '0;
            else if (cmd.push)
                fill_reg <= fill_reg + 6'd1;

            if (cmd.restart)
                total_reg <= '0;
            else if (cmd.count_byte)
                total_reg <= total_reg + 61'd1;

            if (cmd.restart)
            begin
                h_reg[0] <= sha1bh_pkg::IV0;
                h_reg[1] <= sha1bh_pkg::IV1;
                h_reg[2] <= sha1bh_pkg::IV2;
                h_reg[3] <= sha1bh_pkg::IV3;
                h_reg[4] <= sha1bh_pkg::IV4;
            end
            else if (cmd.fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
        end
    end

    // digest output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (digest.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.digest_word0 <= h_reg[0];
            out_reg.digest_word1 <= h_reg[1];
            out_reg.digest_word2 <= h_reg[2];
            out_reg.digest_word3 <= h_reg[3];
            out_reg.digest_word4 <= h_reg[4];
        end
    end

    assign digest.valid   = out_valid_reg;
    assign digest.payload = out_reg;

    assign status.fill    = fill_reg;
    assign status.emit_ok = !out_valid_reg || digest.ready;

endmodule

FILE: sv/sha1_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 hasher fed one message byte per item; a finish item pads the message
// and returns the five digest words as one item.
// ----------------------------------------------------------------------------
// A data byte is taken while the core is idle. Every 64th byte closes a block,
// and the input then stays not ready while the 80 rounds run through the single
// round unit and the result is added into the chaining value. A finish item is
// taken; the core then pushes the pad bytes (9 to 72), moves on to the length
// field, runs one or two blocks and loads the digest register; that register
// holds a digest while the next message streams in, and loading the next
// digest waits only if the previous digest is still not taken. After a digest
// the core starts over from the standard initial hash value.
module sha1_byte_stream_hasher_core (
    input  logic            clk,
    input  logic            rst_n,
    sha1bh_stream_if.sink   msg,
    sha1bh_stream_if.source digest
);

    sha1bh_pkg::cmd_t    cmd;
    sha1bh_pkg::status_t status;
    sha1bh_pkg::msg_item_t msg_item;
    logic                in_ready;

    assign msg_item  = msg.payload;
    assign msg.ready = in_ready;

    // sequencer
    sha1bh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_kind  (msg_item.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hashing datapath
    sha1bh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg_item.data_byte),
        .cmd       (cmd),
        .status    (status),
        .digest    (digest)
    );

endmodule
